[design/sfs_pkg.sv]
package sfs_pkg;

   localparam int unsigned TempWidth = 12;

   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_TIMER = 2'd1;
   localparam logic [1:0] REQ_RISE  = 2'd2;
   localparam logic [1:0] REQ_SET   = 2'd3;

   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_RISE = 2'd1;
   localparam logic [1:0] MODE_SET  = 2'd2;

   localparam logic [TempWidth-1:0] TEMP_RISE_START = 12'd2000;
   localparam logic [TempWidth-1:0] TEMP_SET_START  = 12'd3500;
   localparam logic [TempWidth-1:0] TEMP_FADE_START = 12'd2255;
   localparam logic [7:0]           LEVEL_MAX       = 8'd255;
   localparam logic [15:0]          STEP_RESET      = 16'd1200;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] now_ms;
   } req_payload_type;

   typedef struct packed {
      logic       updated;
      logic [1:0] run_mode;
      logic [7:0] applied_level;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   function automatic logic [7:0] green_lookup(input logic [3:0] idx);
      logic [7:0] val;
      case (idx)
         4'd0:    val = 8'd136;
         4'd1:    val = 8'd141;
         4'd2:    val = 8'd146;
         4'd3:    val = 8'd150;
         4'd4:    val = 8'd155;
         4'd5:    val = 8'd159;
         4'd6:    val = 8'd162;
         4'd7:    val = 8'd166;
         4'd8:    val = 8'd170;
         4'd9:    val = 8'd173;
         4'd10:   val = 8'd177;
         4'd11:   val = 8'd180;
         4'd12:   val = 8'd183;
         4'd13:   val = 8'd186;
         4'd14:   val = 8'd189;
         default: val = 8'd192;
      endcase
      return val;
   endfunction

   function automatic logic [7:0] blue_lookup(input logic [3:0] idx);
      logic [7:0] val;
      case (idx)
         4'd0:    val = 8'd13;
         4'd1:    val = 8'd27;
         4'd2:    val = 8'd39;
         4'd3:    val = 8'd50;
         4'd4:    val = 8'd60;
         4'd5:    val = 8'd70;
         4'd6:    val = 8'd79;
         4'd7:    val = 8'd87;
         4'd8:    val = 8'd95;
         4'd9:    val = 8'd102;
         4'd10:   val = 8'd109;
         4'd11:   val = 8'd116;
         4'd12:   val = 8'd123;
         4'd13:   val = 8'd129;
         4'd14:   val = 8'd135;
         default: val = 8'd140;
      endcase
      return val;
   endfunction

endpackage

[design/sunrise_fade_sequencer.sv]
// Sunrise/sunset lamp sequencer.
// req channel: one transfer per event (tick, start timer, begin rise, begin set)
//   with the current millisecond time in now_ms.
// rsp channel: exactly one result per request, in order: whether the tick
//   stepped the color temperature, the ramp mode, the applied brightness and
//   the RGB color now shown.
// csr channel: writes step_interval (ms); always ready, write only while idle.
// The result is registered and shows in the cycle after the request transfer.
// Throughput: one request per cycle unless a held result stalls; all state is
//   updated by one pass of logic (32-bit elapsed compare, increment or decrement,
//   a 16-entry color table) between the state registers and the result register.
// A stalled receiver holds the result; req_ready drops only while a result
//   is held and rsp_ready is low, and rises in the cycle the result is taken.
// Reset (synchronous, active high): idle, temperature and levels zero, color
//   black, last step time zero, step_interval 1200 ms, no result pending.
module sunrise_fade_sequencer
   import sfs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [15:0]     csr_data
);

   logic [15:0]          interval_ff;
   logic [31:0]          last_ff, last_in;
   logic [TempWidth-1:0] temp_ff, temp_in;
   logic [1:0]           mode_ff, mode_in;
   logic [7:0]           level_ff, level_in;
   logic [7:0]           applied_ff, applied_in;
   rgb_type              color_ff, color_in, lut_color;
   logic                 updated_in;
   logic                 rsp_valid_ff;
   rsp_payload_type      rsp_ff;

   logic        req_fire;
   logic [31:0] elapsed;
   logic        due;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign elapsed = req_payload.now_ms - last_ff;
   assign due     = elapsed > {16'd0, interval_ff};

   sfs_color_lut u_lut (
      .kelvin (temp_in),
      .color  (lut_color)
   );

   always_comb begin
      last_in    = last_ff;
      temp_in    = temp_ff;
      mode_in    = mode_ff;
      level_in   = level_ff;
      applied_in = applied_ff;
      color_in   = color_ff;
      updated_in = 1'b0;
      case (req_payload.req_type)
         REQ_TICK: begin
            if (due) begin
               if (mode_ff == MODE_RISE && temp_ff < TEMP_SET_START) begin
                  if (level_ff < LEVEL_MAX) begin
                     applied_in = level_ff;
                     level_in   = level_ff + 8'd1;
                  end
                  temp_in    = temp_ff + 12'd1;
                  updated_in = 1'b1;
               end else if (mode_ff == MODE_SET && temp_ff > TEMP_RISE_START) begin
                  if (temp_ff <= TEMP_FADE_START && level_ff != 8'd0) begin
                     applied_in = level_ff;
                     level_in   = level_ff - 8'd1;
                  end
                  temp_in    = temp_ff - 12'd1;
                  updated_in = 1'b1;
               end else begin
                  mode_in = MODE_IDLE;
               end
               if (updated_in) begin
                  last_in  = req_payload.now_ms;
                  color_in = lut_color;
               end
            end
         end
         REQ_TIMER: begin
            last_in = req_payload.now_ms;
         end
         REQ_RISE: begin
            temp_in    = TEMP_RISE_START;
            mode_in    = MODE_RISE;
            level_in   = 8'd0;
            applied_in = 8'd0;
         end
         default: begin
            temp_in    = TEMP_SET_START;
            mode_in    = MODE_SET;
            level_in   = LEVEL_MAX;
            applied_in = LEVEL_MAX;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff  <= STEP_RESET;
         last_ff      <= '0;
         temp_ff      <= '0;
         mode_ff      <= MODE_IDLE;
         level_ff     <= '0;
         applied_ff   <= '0;
         color_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            interval_ff <= csr_data;
         end
         if (req_fire) begin
            last_ff      <= last_in;
            temp_ff      <= temp_in;
            mode_ff      <= mode_in;
            level_ff     <= level_in;
            applied_ff   <= applied_in;
            color_ff     <= color_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff.updated       <= updated_in;
         rsp_ff.run_mode      <= mode_in;
         rsp_ff.applied_level <= applied_in;
         rsp_ff.red           <= color_in.red;
         rsp_ff.green         <= color_in.green;
         rsp_ff.blue          <= color_in.blue;
      end
   end

   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      temp_ff == '0 || (temp_ff >= TEMP_RISE_START && temp_ff <= TEMP_SET_START))
      else $error("color temperature out of ramp range");

   // the last set step lands on 2000 K and shows black, so only the mode is checked
   a_step_not_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.updated |-> rsp_ff.run_mode != MODE_IDLE)
      else $error("step reported while idle");

   a_rise_start: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_payload.req_type == REQ_RISE |=>
         level_ff == 8'd0 && mode_ff == MODE_RISE && temp_ff == TEMP_RISE_START)
      else $error("begin rise did not load ramp start");

   a_result_matches_state: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_ff.run_mode == mode_ff && rsp_ff.applied_level == applied_ff)
      else $error("result does not reflect updated state");

endmodule

[design/sfs_color_lut.sv]
module sfs_color_lut
   import sfs_pkg::*;
(
   input  logic [TempWidth-1:0] kelvin,
   output rgb_type              color
);

   localparam logic [5:0] IdxFirst = 6'd20;
   localparam logic [5:0] IdxLast  = 6'd35;

   logic [24:0] recip_prod;
   logic [5:0]  hundreds;
   logic [5:0]  clamped;
   logic [3:0]  tab_idx;

   // kelvin / 100 as multiply by 5243 >> 19, exact over the 12-bit range
   assign recip_prod = {13'd0, kelvin} * 25'd5243;
   assign hundreds   = recip_prod[24:19];
   assign clamped    = (hundreds > IdxLast) ? IdxLast : hundreds;
   assign tab_idx    = 4'(clamped - IdxFirst);

   always_comb begin
      if (kelvin <= TEMP_RISE_START) begin
         color = '0;
      end else begin
         color.red   = 8'd255;
         color.green = green_lookup(tab_idx);
         color.blue  = blue_lookup(tab_idx);
      end
   end

endmodule

[verif/testbench.sv]
module testbench;
   import sfs_pkg::*;

   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned RANDOM_ITEMS = 900;

   // Tracks the lamp state and keeps the responses still owed by the block.
   class fade_tracker;
      logic [15:0]          step_interval;
      logic [31:0]          last_step_ms;
      logic [TempWidth-1:0] kelvin;
      logic [1:0]           mode;
      logic [7:0]           level_count;
      logic [7:0]           shown_level;
      rgb_type              shown_rgb;
      rsp_payload_type      expected_lamp[$];
      int unsigned          errors;

      logic [7:0] green_by_hundred [16] = '{136, 141, 146, 150, 155, 159, 162, 166,
                                            170, 173, 177, 180, 183, 186, 189, 192};
      logic [7:0] blue_by_hundred  [16] = '{13, 27, 39, 50, 60, 70, 79, 87,
                                            95, 102, 109, 116, 123, 129, 135, 140};

      function new();
         step_interval = STEP_RESET;
         last_step_ms  = '0;
         kelvin        = '0;
         mode          = MODE_IDLE;
         level_count   = '0;
         shown_level   = '0;
         shown_rgb     = '0;
         errors        = 0;
      endfunction

      function void set_interval(input logic [15:0] value);
         step_interval = value;
      endfunction

      function bit ramping();
         return mode != MODE_IDLE;
      endfunction

      function int pending();
         return expected_lamp.size();
      endfunction

      function rgb_type kelvin_to_rgb(input logic [TempWidth-1:0] k);
         rgb_type rgb;
         int      idx;
         rgb = '0;
         if (k > TEMP_RISE_START) begin
            idx = int'(k) / 100;
            if (idx > 35)
               idx = 35;
            idx = idx - 20;
            rgb.red   = 8'd255;
            rgb.green = green_by_hundred[idx];
            rgb.blue  = blue_by_hundred[idx];
         end
         return rgb;
      endfunction

      function void apply_event(input req_payload_type req);
         rsp_payload_type lamp;
         logic [31:0]     elapsed;
         lamp = '0;
         case (req.req_type)
            REQ_TICK: begin
               elapsed = req.now_ms - last_step_ms;
               if (elapsed > {16'd0, step_interval}) begin
                  if (mode == MODE_RISE && kelvin < TEMP_SET_START) begin
                     if (level_count < LEVEL_MAX) begin
                        shown_level = level_count;
                        level_count = level_count + 8'd1;
                     end
                     kelvin = kelvin + 1'b1;
                     lamp.updated = 1'b1;
                  end else if (mode == MODE_SET && kelvin > TEMP_RISE_START) begin
                     if (kelvin <= TEMP_FADE_START && level_count > 0) begin
                        shown_level = level_count;
                        level_count = level_count - 8'd1;
                     end
                     kelvin = kelvin - 1'b1;
                     lamp.updated = 1'b1;
                  end else begin
                     mode = MODE_IDLE;
                  end
                  if (lamp.updated) begin
                     last_step_ms = req.now_ms;
                     shown_rgb = kelvin_to_rgb(kelvin);
                  end
               end
            end
            REQ_TIMER: last_step_ms = req.now_ms;
            REQ_RISE: begin
               kelvin      = TEMP_RISE_START;
               mode        = MODE_RISE;
               level_count = '0;
               shown_level = '0;
            end
            REQ_SET: begin
               kelvin      = TEMP_SET_START;
               mode        = MODE_SET;
               level_count = LEVEL_MAX;
               shown_level = LEVEL_MAX;
            end
         endcase
         lamp.run_mode      = mode;
         lamp.applied_level = shown_level;
         lamp.red           = shown_rgb.red;
         lamp.green         = shown_rgb.green;
         lamp.blue          = shown_rgb.blue;
         expected_lamp.push_back(lamp);
      endfunction

      function void check_lamp_output(input rsp_payload_type got);
         rsp_payload_type want;
         if (expected_lamp.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected response: upd=%0d mode=%0d lvl=%0d rgb=%0d/%0d/%0d",
                        got.updated, got.run_mode, got.applied_level,
                        got.red, got.green, got.blue);
            return;
         end
         want = expected_lamp.pop_front();
         if (got.updated !== want.updated || got.run_mode !== want.run_mode ||
             got.applied_level !== want.applied_level || got.red !== want.red ||
             got.green !== want.green || got.blue !== want.blue) begin
            errors++;
            if (errors <= 10) begin
               $write("mismatch: exp upd=%0d mode=%0d lvl=%0d rgb=%0d/%0d/%0d",
                      want.updated, want.run_mode, want.applied_level,
                      want.red, want.green, want.blue);
               $display(", got upd=%0d mode=%0d lvl=%0d rgb=%0d/%0d/%0d",
                        got.updated, got.run_mode, got.applied_level,
                        got.red, got.green, got.blue);
            end
         end
      endfunction

      function void flag_leftovers();
         if (expected_lamp.size() != 0) begin
            $display("%0d responses never arrived", expected_lamp.size());
            errors += expected_lamp.size();
         end
      endfunction
   endclass

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic [15:0]     csr_data = '0;

   fade_tracker tracker = new();

   int unsigned burst_left = 0;
   int unsigned sent_count = 0;
   int unsigned quiet_cycles = 0;
   int unsigned stall_phase = 0;
   logic [7:0]  stall_pattern = 8'hFF;
   logic [31:0] stamp = '0;

   always #10 clock = ~clock;

   sunrise_fade_sequencer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   // monitor: both sides sampled at the edge on pre-edge values
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            tracker.apply_event(req_payload);
         if (rsp_valid && rsp_ready)
            tracker.check_lamp_output(rsp_payload);
      end
   end

   // receiver stall pattern, chosen at random from three kinds; always at least one ready slot
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 64 == 63) begin
         case ($urandom_range(0, 2))
            0:       stall_pattern <= 8'hFF;
            1:       stall_pattern <= 8'($urandom) | 8'h01;
            default: stall_pattern <= 8'h01 << $urandom_range(0, 7);
         endcase
      end
      rsp_ready <= stall_pattern[stall_phase[2:0]];
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(input logic [1:0] kind, input logic [31:0] stamp_ms);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 48);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= '{req_type: kind, now_ms: stamp_ms};
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   task automatic write_interval(input logic [15:0] value);
      hold_until_drained();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tracker.set_interval(value);
   endtask

   // well-formed ramp: optional timer start, rise or set, then mostly stepping ticks
   task automatic run_ramp(input logic [1:0] start_cmd, input int unsigned max_ticks,
                           input bit until_idle);
      logic [31:0] interval_ms;
      logic [1:0]  kind;
      int unsigned roll;
      int unsigned extra;
      interval_ms = {16'd0, tracker.step_interval};
      extra = 0;
      if ($urandom_range(0, 3) != 0)
         send_request(REQ_TIMER, stamp);
      send_request(start_cmd, $urandom);
      for (int unsigned n = 0; n < max_ticks; n++) begin
         // tracker state may lag one transfer; an extra tick is harmless
         if (until_idle && !tracker.ramping()) begin
            extra++;
            if (extra > 3)
               break;
         end
         kind = REQ_TICK;
         roll = $urandom_range(0, 99);
         if (roll < 82)
            stamp = stamp + interval_ms + 1 + $urandom_range(0, 40);
         else if (roll < 85)
            stamp = stamp + interval_ms;
         else if (roll < 90)
            stamp = stamp + $urandom_range(0, interval_ms);
         else if (roll < 95)
            stamp = $urandom;
         else
            kind = REQ_TIMER;
         send_request(kind, stamp);
      end
   endtask

   task automatic send_noise(input int unsigned count);
      logic [31:0] stamp_ms;
      repeat (count) begin
         stamp_ms = ($urandom_range(0, 1) == 0) ? $urandom : stamp + $urandom_range(0, 2000);
         send_request(2'($urandom_range(0, 3)), stamp_ms);
      end
   endtask

   initial begin
      int unsigned random_start;
      logic [15:0] interval;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // idle ticks, wrapped elapsed time, exact-interval boundary, command overrides
      send_request(REQ_TICK, 32'd0);
      send_request(REQ_TICK, 32'hFFFF_FFFF);
      send_request(REQ_TIMER, 32'hFFFF_FFFF);
      send_request(REQ_RISE, 32'h0);
      send_request(REQ_TICK, 32'd1199);
      send_request(REQ_TICK, 32'd1200);
      send_request(REQ_TICK, 32'd2401);
      send_request(REQ_SET, 32'hFFFF_FFFF);
      send_request(REQ_TICK, 32'd3602);
      send_request(REQ_TIMER, 32'd0);
      send_request(REQ_TICK, 32'd1201);
      send_request(REQ_SET, 32'h5555_5555);
      send_request(REQ_RISE, 32'hAAAA_AAAA);
      send_request(REQ_TICK, 32'hFFFF_FFFF);
      send_request(REQ_TIMER, 32'h8000_0000);
      send_request(REQ_TICK, 32'h7FFF_FFFF);
      send_request(REQ_TICK, 32'h7FFF_FFFF);
      send_request(REQ_TICK, 32'h0000_04B0);

      stamp = $urandom;
      random_start = sent_count;
      while (sent_count - random_start < RANDOM_ITEMS) begin
         case ($urandom_range(0, 4))
            0:       interval = 16'd0;
            1:       interval = 16'hFFFF;
            2:       interval = STEP_RESET;
            3:       interval = 16'($urandom_range(1, 20));
            default: interval = 16'($urandom);
         endcase
         write_interval(interval);
         repeat ($urandom_range(2, 6)) begin
            if ($urandom_range(0, 9) < 7)
               run_ramp($urandom_range(0, 1) ? REQ_RISE : REQ_SET,
                        $urandom_range(1, 120), 1'b0);
            else
               send_noise($urandom_range(1, 15));
         end
      end

      hold_until_drained();
      repeat (4) @(posedge clock);
      tracker.flag_leftovers();
      if (tracker.errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

[filelist.f]
design/sfs_pkg.sv
design/sfs_color_lut.sv
design/sunrise_fade_sequencer.sv
verif/testbench.sv
